FILE: hw/rtl/tgs_pkg.sv
// Shared types and constants for the tridiagonal Gauss-Seidel solver.
// Used by tgs_ctrl, tgs_datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tgs_pkg;

	// action codes of an input word
	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_RUN  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	// register indexes on the APB port
	localparam logic REG_ROW_COUNT   = 1'b0;
	localparam logic REG_SWEEP_COUNT = 1'b1;

	// fixed word widths and divide step count
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 64;
	localparam int ACC_W     = 66;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = 5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_FETCH,
		ST_MUL_LO,
		ST_MUL_UP,
		ST_SUB,
		ST_ABS,
		ST_CHK,
		ST_DIV,
		ST_WB
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_READ,
		DP_OUT,
		DP_FETCH,
		DP_MUL_LO,
		DP_MUL_UP,
		DP_SUB,
		DP_ABS,
		DP_CHK,
		DP_DIV,
		DP_WB
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   first_row;
		logic   last_row;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tgs_ctrl.sv
// Controller of the solver: state machine, row, sweep and divide counters.
// Depends on tgs_pkg; drives tgs_datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module tgs_ctrl #(
	parameter int MAX_ROWS = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire  [1:0]                   action,
	input  wire  [6:0]                   row_count,
	input  wire  [15:0]                  sweep_count,
	input  tgs_pkg::dp_status_t          status,
	output logic                         in_stall,
	output tgs_pkg::dp_cmd_t             cmd,
	output logic [$clog2(MAX_ROWS)-1:0]  row_addr
);

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int NW    = (ROW_W + 1 > 7) ? ROW_W + 1 : 7;

	tgs_pkg::state_t state_q, state_d;
	logic [ROW_W-1:0]              row_q;
	logic [15:0]                   sweep_q;
	logic [tgs_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [NW-1:0]                 n_raw, n_eff;
	logic                          accept, last_row, last_sweep, div_last;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != tgs_pkg::ST_IDLE) || status.out_busy;

	// effective row count, clamped to 2 .. MAX_ROWS
	assign n_raw = NW'(row_count);
	always_comb begin
		n_eff = n_raw;
		if (n_raw < NW'(2)) begin
			n_eff = NW'(2);
		end else if (n_raw > NW'(MAX_ROWS)) begin
			n_eff = NW'(MAX_ROWS);
		end
	end

	assign last_row   = (NW'(row_q) + NW'(1)) == n_eff;
	assign last_sweep = (sweep_q + 16'd1) == sweep_count;
	assign div_last   = div_cnt_q == tgs_pkg::DIV_CNT_W'(tgs_pkg::DIV_STEPS - 1);
	assign row_addr   = row_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tgs_pkg::ST_IDLE: begin
				if (accept && action == tgs_pkg::ACT_READ) begin
					state_d = tgs_pkg::ST_READ;
				end else if (accept && action == tgs_pkg::ACT_RUN && sweep_count != 16'd0) begin
					state_d = tgs_pkg::ST_FETCH;
				end
			end
			tgs_pkg::ST_READ:   state_d = tgs_pkg::ST_IDLE;
			tgs_pkg::ST_FETCH:  state_d = tgs_pkg::ST_MUL_LO;
			tgs_pkg::ST_MUL_LO: state_d = tgs_pkg::ST_MUL_UP;
			tgs_pkg::ST_MUL_UP: state_d = tgs_pkg::ST_SUB;
			tgs_pkg::ST_SUB:    state_d = tgs_pkg::ST_ABS;
			tgs_pkg::ST_ABS:    state_d = tgs_pkg::ST_CHK;
			tgs_pkg::ST_CHK:    state_d = tgs_pkg::ST_DIV;
			tgs_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = tgs_pkg::ST_WB;
				end
			end
			tgs_pkg::ST_WB: begin
				if (last_row && last_sweep) begin
					state_d = tgs_pkg::ST_IDLE;
				end else begin
					state_d = tgs_pkg::ST_FETCH;
				end
			end
			default: state_d = tgs_pkg::ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.op        = tgs_pkg::DP_NOP;
		cmd.first_row = row_q == '0;
		cmd.last_row  = last_row;
		unique case (state_q)
			tgs_pkg::ST_IDLE: begin
				if (accept && action == tgs_pkg::ACT_LOAD) begin
					cmd.op = tgs_pkg::DP_LOAD;
				end else if (accept && action == tgs_pkg::ACT_READ) begin
					cmd.op = tgs_pkg::DP_READ;
				end
			end
			tgs_pkg::ST_READ:   cmd.op = tgs_pkg::DP_OUT;
			tgs_pkg::ST_FETCH:  cmd.op = tgs_pkg::DP_FETCH;
			tgs_pkg::ST_MUL_LO: cmd.op = tgs_pkg::DP_MUL_LO;
			tgs_pkg::ST_MUL_UP: cmd.op = tgs_pkg::DP_MUL_UP;
			tgs_pkg::ST_SUB:    cmd.op = tgs_pkg::DP_SUB;
			tgs_pkg::ST_ABS:    cmd.op = tgs_pkg::DP_ABS;
			tgs_pkg::ST_CHK:    cmd.op = tgs_pkg::DP_CHK;
			tgs_pkg::ST_DIV:    cmd.op = tgs_pkg::DP_DIV;
			tgs_pkg::ST_WB:     cmd.op = tgs_pkg::DP_WB;
			default:            cmd.op = tgs_pkg::DP_NOP;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tgs_pkg::ST_IDLE;
			row_q     <= '0;
			sweep_q   <= '0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tgs_pkg::ST_IDLE) begin
				row_q   <= '0;
				sweep_q <= '0;
			end
			if (state_q == tgs_pkg::ST_CHK) begin
				div_cnt_q <= '0;
			end else if (state_q == tgs_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q + tgs_pkg::DIV_CNT_W'(1);
			end
			if (state_q == tgs_pkg::ST_WB) begin
				if (last_row) begin
					row_q   <= '0;
					sweep_q <= sweep_q + 16'd1;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tgs_datapath.sv
// Datapath of the solver: row stores, one multiplier, accumulator,
// restoring divider, saturation and the output register. Depends on tgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgs_datapath #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  tgs_pkg::dp_cmd_t             cmd,
	input  wire  [$clog2(MAX_ROWS)-1:0]  row_addr,
	input  wire  [$clog2(MAX_ROWS)-1:0]  row_index,
	input  wire  [31:0]                  lower_coef,
	input  wire  [31:0]                  main_coef,
	input  wire  [31:0]                  upper_coef,
	input  wire  [31:0]                  rhs_value,
	input  wire  [31:0]                  initial_guess,
	input  wire                          out_stall,
	output tgs_pkg::dp_status_t          status,
	output logic                         out_valid,
	output logic [31:0]                  solution_value,
	output logic [$clog2(MAX_ROWS)-1:0]  row_out,
	output logic                         fault
);

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int AW    = tgs_pkg::ACC_W;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_MIN = 32'h8000_0000;

	logic [31:0] lower_mem [MAX_ROWS];
	logic [31:0] main_mem  [MAX_ROWS];
	logic [31:0] upper_mem [MAX_ROWS];
	logic [31:0] rhs_mem   [MAX_ROWS];
	logic [31:0] sol_mem   [MAX_ROWS];

	logic [31:0] rhs_q, main_q, up_q, lo_q, yn_q, yprev_q;
	logic signed [63:0] prod_q;
	logic signed [AW-1:0] acc_q, acc_ext_rhs, acc_mag;
	logic [AW-33:0] mag_hi_q;
	logic [31:0] dvd_q, rem_q, quo_q, den_mag_q;
	logic num_neg_q, num_zero_q, den_neg_q, zden_q, ovf_q;
	logic [ROW_W-1:0] rd_row_q;
	logic rd_ok_q, fault_q, out_valid_q, in_range;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_res;
	logic [32:0] rem_sh;
	logic rem_ge, q_neg, wb_fault;
	logic [31:0] wb_res;

	assign in_range = {1'b0, row_index} < (ROW_W + 1)'(MAX_ROWS);
	assign status.out_busy = out_valid_q && out_stall;

	// shared multiplier: lower term first, upper term next
	assign mul_a   = (cmd.op == tgs_pkg::DP_MUL_LO) ? $signed(lo_q) : $signed(up_q);
	assign mul_b   = (cmd.op == tgs_pkg::DP_MUL_LO) ? $signed(yprev_q) : $signed(yn_q);
	assign mul_res = mul_a * mul_b;

	assign acc_ext_rhs = $signed({{(AW - 32){rhs_q[31]}}, rhs_q}) <<< FRAC_BITS;
	assign acc_mag     = acc_q[AW-1] ? -acc_q : acc_q;

	// one restoring divide step
	assign rem_sh = {rem_q, dvd_q[31]};
	assign rem_ge = rem_sh >= {1'b0, den_mag_q};

	// quotient sign handling and saturation
	assign q_neg = num_neg_q ^ den_neg_q;
	always_comb begin
		wb_fault = 1'b0;
		wb_res   = quo_q;
		if (zden_q) begin
			wb_fault = 1'b1;
			wb_res   = num_zero_q ? 32'd0 : (num_neg_q ? NEG_MIN : POS_MAX);
		end else if (ovf_q) begin
			wb_fault = 1'b1;
			wb_res   = q_neg ? NEG_MIN : POS_MAX;
		end else if (q_neg) begin
			if (quo_q > NEG_MIN) begin
				wb_fault = 1'b1;
				wb_res   = NEG_MIN;
			end else begin
				wb_res = -quo_q;
			end
		end else if (quo_q >= NEG_MIN) begin
			wb_fault = 1'b1;
			wb_res   = POS_MAX;
		end
	end

	// row stores and working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			tgs_pkg::DP_LOAD: begin
				if (in_range) begin
					lower_mem[row_index] <= lower_coef;
					main_mem[row_index]  <= main_coef;
					upper_mem[row_index] <= upper_coef;
					rhs_mem[row_index]   <= rhs_value;
					sol_mem[row_index]   <= initial_guess;
				end
			end
			tgs_pkg::DP_READ: begin
				yn_q     <= sol_mem[row_index];
				rd_row_q <= row_index;
				rd_ok_q  <= in_range;
			end
			tgs_pkg::DP_FETCH: begin
				rhs_q  <= rhs_mem[row_addr];
				main_q <= main_mem[row_addr];
				up_q   <= upper_mem[row_addr];
				lo_q   <= lower_mem[row_addr - ROW_W'(1)];
				yn_q   <= sol_mem[row_addr + ROW_W'(1)];
			end
			tgs_pkg::DP_MUL_LO: begin
				prod_q <= mul_res;
				acc_q  <= acc_ext_rhs;
			end
			tgs_pkg::DP_MUL_UP: begin
				prod_q <= mul_res;
				if (!cmd.first_row) begin
					acc_q <= acc_q - {{(AW - 64){prod_q[63]}}, prod_q};
				end
			end
			tgs_pkg::DP_SUB: begin
				if (!cmd.last_row) begin
					acc_q <= acc_q - {{(AW - 64){prod_q[63]}}, prod_q};
				end
			end
			tgs_pkg::DP_ABS: begin
				num_neg_q  <= acc_q[AW-1];
				num_zero_q <= acc_q == '0;
				mag_hi_q   <= acc_mag[AW-1:32];
				dvd_q      <= acc_mag[31:0];
				den_neg_q  <= main_q[31];
				den_mag_q  <= main_q[31] ? -main_q : main_q;
			end
			tgs_pkg::DP_CHK: begin
				zden_q <= den_mag_q == 32'd0;
				ovf_q  <= mag_hi_q >= {{(AW - 64){1'b0}}, den_mag_q};
				rem_q  <= mag_hi_q[31:0];
				quo_q  <= '0;
			end
			tgs_pkg::DP_DIV: begin
				rem_q <= rem_ge ? 32'(rem_sh - {1'b0, den_mag_q}) : rem_sh[31:0];
				quo_q <= {quo_q[30:0], rem_ge};
				dvd_q <= {dvd_q[30:0], 1'b0};
			end
			tgs_pkg::DP_WB: begin
				sol_mem[row_addr] <= wb_res;
				yprev_q           <= wb_res;
			end
			tgs_pkg::DP_OUT: begin
				solution_value <= rd_ok_q ? yn_q : 32'd0;
				row_out        <= rd_row_q;
				fault          <= fault_q;
			end
			default: begin
			end
		endcase
	end

	// fault flag and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == tgs_pkg::DP_LOAD && in_range) begin
				fault_q <= 1'b0;
			end else if (cmd.op == tgs_pkg::DP_WB && wb_fault) begin
				fault_q <= 1'b1;
			end
			if (cmd.op == tgs_pkg::DP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tridiagonal_gauss_seidel_solver.sv
// Top level of the tridiagonal Gauss-Seidel solver: APB registers,
// controller and datapath. Depends on tgs_pkg, tgs_ctrl, tgs_datapath.
//
// Use: write row_count (0x0) and sweep_count (0x4) over APB while idle.
// Input words (in_valid / in_stall) carry an action: load stores one row
// of the system and its starting guess and clears the fault flag; run
// performs sweep_count sweeps in place; read returns one solution word on
// the output channel (out_valid / out_stall) with row_out and the sticky
// fault flag. Load and run give no output word.
// A load writes its row into the row stores. A read first latches the stored
// word and its row, then loads the output register, where the word is valid.
// A run of sweep_count sweeps over the n clamped rows takes each row through
// a memory fetch, two passes of the shared multiplier, two accumulator steps,
// a magnitude and overflow check, 32 restoring divide steps and a write back.
// The output register holds a word while out_stall is high; a further read
// waits in in_stall until that word is taken. Reset clears the state
// machine, fault flag and output valid; the row stores are undefined until
// loaded.
`timescale 1ns / 1ps
`default_nettype none

module tridiagonal_gauss_seidel_solver #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [2:0]                   paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [1:0]                   action,
	input  wire  [$clog2(MAX_ROWS)-1:0]  row_index,
	input  wire  [31:0]                  lower_coef,
	input  wire  [31:0]                  main_coef,
	input  wire  [31:0]                  upper_coef,
	input  wire  [31:0]                  rhs_value,
	input  wire  [31:0]                  initial_guess,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [31:0]                  solution_value,
	output logic [$clog2(MAX_ROWS)-1:0]  row_out,
	output logic                         fault
);

	localparam int ROW_W = $clog2(MAX_ROWS);

	logic [6:0]  row_count_q;
	logic [15:0] sweep_count_q;
	logic        cfg_wr;
	tgs_pkg::dp_cmd_t    cmd;
	tgs_pkg::dp_status_t status;
	logic [ROW_W-1:0]    row_addr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q   <= 7'd2;
			sweep_count_q <= 16'd0;
		end else if (cfg_wr) begin
			if (paddr[2] == tgs_pkg::REG_ROW_COUNT) begin
				row_count_q <= pwdata[6:0];
			end else begin
				sweep_count_q <= pwdata[15:0];
			end
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[2])
			tgs_pkg::REG_ROW_COUNT:   prdata = {25'd0, row_count_q};
			tgs_pkg::REG_SWEEP_COUNT: prdata = {16'd0, sweep_count_q};
			default:                  prdata = 32'd0;
		endcase
	end

	tgs_ctrl #(
		.MAX_ROWS(MAX_ROWS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.action     (action),
		.row_count  (row_count_q),
		.sweep_count(sweep_count_q),
		.status     (status),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.row_addr   (row_addr)
	);

	tgs_datapath #(
		.MAX_ROWS (MAX_ROWS),
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.row_addr      (row_addr),
		.row_index     (row_index),
		.lower_coef    (lower_coef),
		.main_coef     (main_coef),
		.upper_coef    (upper_coef),
		.rhs_value     (rhs_value),
		.initial_guess (initial_guess),
		.out_stall     (out_stall),
		.status        (status),
		.out_valid     (out_valid),
		.solution_value(solution_value),
		.row_out       (row_out),
		.fault         (fault)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/tgs_checker.sv
// Port-level checks for the solver top level, and the bind that attaches them.
// Depends on tgs_pkg and tridiagonal_gauss_seidel_solver.
`timescale 1ns / 1ps
`default_nettype none

module tgs_checker #(
	parameter int ROW_W = 6
) (
	input wire             clk,
	input wire             arst_n,
	input wire             in_valid,
	input wire             in_stall,
	input wire [1:0]       action,
	input wire             out_valid,
	input wire             out_stall,
	input wire [31:0]      solution_value,
	input wire [ROW_W-1:0] row_out,
	input wire             fault
);

	logic rd_acc;
	assign rd_acc = in_valid && !in_stall && action == tgs_pkg::ACT_READ;

	// a stalled output word stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// a stalled output word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(solution_value) && $stable(row_out)
			&& $stable(fault))
		else $error("output payload changed while stalled");

	// an accepted read blocks input until its word is produced
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_acc |=> in_stall)
		else $error("input taken during a read");

	// a read word shows up on out_valid after the read passes ST_READ and the output register
	a_read_word: assert property (@(posedge clk) disable iff (!arst_n)
		rd_acc |-> ##2 out_valid)
		else $error("read produced no output word");

	// no output word appears without a read
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(rd_acc, 2))
		else $error("output word without a read");

endmodule

bind tridiagonal_gauss_seidel_solver tgs_checker #(
	.ROW_W($clog2(MAX_ROWS))
) u_tgs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.action        (action),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.solution_value(solution_value),
	.row_out       (row_out),
	.fault         (fault)
);

`default_nettype wire
